FILE: hdl/c2a_pkg.sv
// Shared types, constants and segment tables for the CO2 absorbance to ppm block
package c2a_pkg;

	localparam int ADC_BITS_DEF = 10;
	localparam int CNT_W        = 10;
	localparam int TEMP_W       = 12;
	localparam int TLIM_W       = 11;
	localparam int ABS_W        = 10;
	localparam int PPM_W        = 18;
	localparam int DIV_W        = 25;
	localparam int DVS_W        = 10;
	localparam int SEG_W        = 3;
	localparam int PROD_W       = 25;
	localparam int DY_W         = 17;
	localparam int APB_AW       = 5;
	localparam int APB_DW       = 32;

	localparam int ABS_FULL     = 1000;
	localparam int ABS_PPM_MAX  = 523;

	localparam logic [CNT_W-1:0]  LOW_RAIL_RST   = 10'd0;
	localparam logic [CNT_W-1:0]  HIGH_RAIL_RST  = 10'd1023;
	localparam logic [CNT_W-1:0]  CNT_LIMIT_RST  = 10'd4;
	localparam logic [TLIM_W-1:0] TEMP_LIMIT_RST = 11'd16;
	localparam logic [TEMP_W-1:0] ZERO_TEMP_RST  = 12'd400;

	localparam logic [1:0] REQ_MEASURE = 2'd0;
	localparam logic [1:0] REQ_CAPTURE = 2'd1;
	localparam logic [1:0] REQ_CHECK   = 2'd2;
	localparam logic [1:0] REQ_INIT    = 2'd3;

	localparam logic [2:0] REG_LOW_RAIL  = 3'd0;
	localparam logic [2:0] REG_HIGH_RAIL = 3'd1;
	localparam logic [2:0] REG_CNT_LIM   = 3'd2;
	localparam logic [2:0] REG_TEMP_LIM  = 3'd3;
	localparam logic [2:0] REG_DEF_TEMP  = 3'd4;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [DVS_W-1:0] divisor;
	} div_req_t;

	function automatic logic [SEG_W-1:0] seg_of(input logic [ABS_W-1:0] a);
		logic [SEG_W-1:0] s;
		if (a < ABS_W'(30))
			s = 3'd0;
		else if (a < ABS_W'(83))
			s = 3'd1;
		else if (a < ABS_W'(219))
			s = 3'd2;
		else if (a < ABS_W'(364))
			s = 3'd3;
		else
			s = 3'd4;
		return s;
	endfunction

	function automatic logic [ABS_W-1:0] seg_x1(input logic [SEG_W-1:0] s);
		logic [ABS_W-1:0] v;
		case (s)
			3'd0: v = 10'd0;
			3'd1: v = 10'd30;
			3'd2: v = 10'd83;
			3'd3: v = 10'd219;
			3'd4: v = 10'd364;
			default: v = 10'd0;
		endcase
		return v;
	endfunction

	function automatic logic [DVS_W-1:0] seg_dx(input logic [SEG_W-1:0] s);
		logic [DVS_W-1:0] v;
		case (s)
			3'd0: v = 10'd30;
			3'd1: v = 10'd53;
			3'd2: v = 10'd136;
			3'd3: v = 10'd145;
			3'd4: v = 10'd159;
			default: v = 10'd1;
		endcase
		return v;
	endfunction

	function automatic logic [DY_W-1:0] seg_dy(input logic [SEG_W-1:0] s);
		logic [DY_W-1:0] v;
		case (s)
			3'd0: v = 17'd3800;
			3'd1: v = 17'd5700;
			3'd2: v = 17'd30500;
			3'd3: v = 17'd60000;
			3'd4: v = 17'd100000;
			default: v = 17'd0;
		endcase
		return v;
	endfunction

	// y1 * dx, so that the quotient lands on y1 at the segment start
	function automatic logic [DIV_W-1:0] seg_base(input logic [SEG_W-1:0] s);
		logic [DIV_W-1:0] v;
		case (s)
			3'd0: v = 25'd0;
			3'd1: v = 25'd201400;
			3'd2: v = 25'd1292000;
			3'd3: v = 25'd5800000;
			3'd4: v = 25'd15900000;
			default: v = 25'd0;
		endcase
		return v;
	endfunction

endpackage

FILE: hdl/c2a_div.sv
// Serial restoring divider, one quotient bit per cycle
module c2a_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  c2a_pkg::div_req_t         req,
	output logic                      done,
	output logic [c2a_pkg::DIV_W-1:0] quotient
);

	localparam int DIV_W = c2a_pkg::DIV_W;
	localparam int DVS_W = c2a_pkg::DVS_W;
	localparam int CW    = $clog2(DIV_W);

	logic [DIV_W-1:0] acc_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DVS_W:0]   trial;
	logic [DVS_W:0]   diff;
	logic             fits;

	assign trial = {rem_q, acc_q[DIV_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			acc_q  <= '0;
			rem_q  <= '0;
			dvs_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				acc_q  <= req.dividend;
				rem_q  <= '0;
				dvs_q  <= req.divisor;
				cnt_q  <= CW'(DIV_W - 1);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				acc_q <= {acc_q[DIV_W-2:0], fits};
				rem_q <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = acc_q;

endmodule

FILE: hdl/co2_absorbance_to_ppm.sv
// Top level: NDIR CO2 absorbance and ppm computation with zero calibration
//
// Input channel (in_valid/in_stall) carries req_type, co2_average and temperature;
// a transaction is taken when in_valid is high and in_stall low. Output channel
// (out_valid/out_stall) returns exactly one result transaction per input.
// Registers must be written over the APB port only while the block is idle;
// the block itself does not enforce this. pready is always high.
// A measure transaction runs the shared serial divider for the absorbance
// division when the zero is valid, then for the ppm segment division when the
// held absorbance is below 523; at 523 or more the held ppm is returned as it
// stands. Capture, check and init transactions pass only through the execute
// and done states. One transaction is in work at a time; in_stall is high
// while it is in work, so the next transaction can be accepted in the cycle
// in which out_valid rises.
// The result register lets the next transaction be accepted while a result
// waits; when out_stall holds the result, the next one finishes and waits.
// Reset clears the held absorbance, ppm and zero, sets the zero temperature to
// 25 degC and the registers to their defaults.
module co2_absorbance_to_ppm #(
	parameter int ADC_BITS = c2a_pkg::ADC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [c2a_pkg::APB_AW-1:0]        paddr,
	input  logic [c2a_pkg::APB_DW-1:0]        pwdata,
	output logic [c2a_pkg::APB_DW-1:0]        prdata,
	output logic                              pready,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [1:0]                        req_type,
	input  logic [c2a_pkg::CNT_W-1:0]         co2_average,
	input  logic signed [c2a_pkg::TEMP_W-1:0] temperature,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [c2a_pkg::ABS_W-1:0]         co2_abs,
	output logic [c2a_pkg::PPM_W-1:0]         co2_ppm,
	output logic                              abs_updated,
	output logic                              zero_stable
);

	localparam int CNT_W  = c2a_pkg::CNT_W;
	localparam int TEMP_W = c2a_pkg::TEMP_W;
	localparam int TLIM_W = c2a_pkg::TLIM_W;
	localparam int ABS_W  = c2a_pkg::ABS_W;
	localparam int PPM_W  = c2a_pkg::PPM_W;
	localparam int DIV_W  = c2a_pkg::DIV_W;
	localparam int SEG_W  = c2a_pkg::SEG_W;
	localparam int PROD_W = c2a_pkg::PROD_W;
	localparam int APB_DW = c2a_pkg::APB_DW;
	localparam logic [CNT_W-1:0] AVG_MASK =
		(ADC_BITS >= CNT_W) ? {CNT_W{1'b1}} : CNT_W'((1 << ADC_BITS) - 1);

	typedef enum logic [2:0] {
		S_IDLE, S_EXEC, S_QDIV, S_PPM_MUL, S_PPM_ADD, S_PPM_DIV, S_DONE
	} state_t;

	// configuration
	logic [CNT_W-1:0]  low_rail_q;
	logic [CNT_W-1:0]  high_rail_q;
	logic [CNT_W-1:0]  cnt_lim_q;
	logic [TLIM_W-1:0] temp_lim_q;
	logic [TEMP_W-1:0] def_temp_q;
	logic              cfg_wr;
	logic [2:0]        cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_rail_q  <= c2a_pkg::LOW_RAIL_RST;
			high_rail_q <= c2a_pkg::HIGH_RAIL_RST;
			cnt_lim_q   <= c2a_pkg::CNT_LIMIT_RST;
			temp_lim_q  <= c2a_pkg::TEMP_LIMIT_RST;
			def_temp_q  <= c2a_pkg::ZERO_TEMP_RST;
		end else if (cfg_wr) begin
			case (cfg_idx)
				c2a_pkg::REG_LOW_RAIL:  low_rail_q  <= pwdata[CNT_W-1:0];
				c2a_pkg::REG_HIGH_RAIL: high_rail_q <= pwdata[CNT_W-1:0];
				c2a_pkg::REG_CNT_LIM:   cnt_lim_q   <= pwdata[CNT_W-1:0];
				c2a_pkg::REG_TEMP_LIM:  temp_lim_q  <= pwdata[TLIM_W-1:0];
				c2a_pkg::REG_DEF_TEMP:  def_temp_q  <= pwdata[TEMP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			c2a_pkg::REG_LOW_RAIL:  prdata = APB_DW'(low_rail_q);
			c2a_pkg::REG_HIGH_RAIL: prdata = APB_DW'(high_rail_q);
			c2a_pkg::REG_CNT_LIM:   prdata = APB_DW'(cnt_lim_q);
			c2a_pkg::REG_TEMP_LIM:  prdata = APB_DW'(temp_lim_q);
			c2a_pkg::REG_DEF_TEMP:  prdata = {{(APB_DW-TEMP_W){def_temp_q[TEMP_W-1]}}, def_temp_q};
			default:                prdata = '0;
		endcase
	end

	// datapath state
	state_t             state_q;
	logic [1:0]         req_q;
	logic [CNT_W-1:0]   avg_q;
	logic [TEMP_W-1:0]  temp_q;
	logic [CNT_W-1:0]   zero_count_q;
	logic [TEMP_W-1:0]  zero_temp_q;
	logic [ABS_W-1:0]   abs_hold_q;
	logic [PPM_W-1:0]   ppm_hold_q;
	logic               upd_q;
	logic               stable_q;
	logic [SEG_W-1:0]   seg_q;
	logic [PROD_W-1:0]  prod_q;
	logic               out_valid_q;
	logic [ABS_W-1:0]   out_abs_q;
	logic [PPM_W-1:0]   out_ppm_q;
	logic               out_upd_q;
	logic               out_stable_q;

	c2a_pkg::div_req_t  div_req;
	logic               div_done;
	logic [DIV_W-1:0]   div_quot;

	logic               zero_ok;
	logic [CNT_W-1:0]   dc;
	logic [TEMP_W:0]    dt_raw;
	logic [TEMP_W:0]    dt;
	logic               check_ok;
	logic [SEG_W-1:0]   seg;
	logic [ABS_W-1:0]   abs_off;
	logic               in_acc;

	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;

	assign zero_ok = (zero_count_q != '0) && (zero_count_q != low_rail_q)
		&& (zero_count_q != high_rail_q);
	assign dc       = (avg_q > zero_count_q) ? (avg_q - zero_count_q) : (zero_count_q - avg_q);
	assign dt_raw   = {temp_q[TEMP_W-1], temp_q} - {zero_temp_q[TEMP_W-1], zero_temp_q};
	assign dt       = dt_raw[TEMP_W] ? (~dt_raw + 1'b1) : dt_raw;
	assign check_ok = (dc <= cnt_lim_q) && (dt <= (TEMP_W+1)'(temp_lim_q));
	assign seg      = c2a_pkg::seg_of(abs_hold_q);
	assign abs_off  = abs_hold_q - c2a_pkg::seg_x1(seg);

	always_comb begin
		div_req.start    = 1'b0;
		div_req.dividend = '0;
		div_req.divisor  = '0;
		case (state_q)
			S_EXEC: begin
				if (req_q == c2a_pkg::REQ_MEASURE && zero_ok) begin
					div_req.start    = 1'b1;
					div_req.dividend = DIV_W'(avg_q) * DIV_W'(c2a_pkg::ABS_FULL);
					div_req.divisor  = zero_count_q;
				end
			end
			S_PPM_ADD: begin
				div_req.start    = 1'b1;
				div_req.dividend = prod_q + c2a_pkg::seg_base(seg_q);
				div_req.divisor  = c2a_pkg::seg_dx(seg_q);
			end
			default: ;
		endcase
	end

	c2a_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.done     (div_done),
		.quotient (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			zero_count_q <= '0;
			zero_temp_q  <= c2a_pkg::ZERO_TEMP_RST;
			abs_hold_q   <= '0;
			ppm_hold_q   <= '0;
			out_valid_q  <= 1'b0;
			upd_q        <= 1'b0;
			stable_q     <= 1'b0;
			req_q        <= '0;
			avg_q        <= '0;
			temp_q       <= '0;
			seg_q        <= '0;
			prod_q       <= '0;
			out_abs_q    <= '0;
			out_ppm_q    <= '0;
			out_upd_q    <= 1'b0;
			out_stable_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && state_q != S_DONE)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						req_q    <= req_type;
						avg_q    <= co2_average & AVG_MASK;
						temp_q   <= temperature;
						upd_q    <= 1'b0;
						stable_q <= 1'b0;
						state_q  <= S_EXEC;
					end
				end
				S_EXEC: begin
					case (req_q)
						c2a_pkg::REQ_MEASURE: begin
							state_q <= zero_ok ? S_QDIV : S_PPM_MUL;
						end
						c2a_pkg::REQ_CAPTURE: begin
							zero_count_q <= avg_q;
							zero_temp_q  <= temp_q;
							state_q      <= S_DONE;
						end
						c2a_pkg::REQ_CHECK: begin
							stable_q <= check_ok;
							state_q  <= S_DONE;
						end
						default: begin
							zero_count_q <= avg_q;
							zero_temp_q  <= def_temp_q;
							abs_hold_q   <= '0;
							ppm_hold_q   <= '0;
							state_q      <= S_DONE;
						end
					endcase
				end
				S_QDIV: begin
					if (div_done) begin
						if (div_quot <= DIV_W'(c2a_pkg::ABS_FULL)) begin
							abs_hold_q <= ABS_W'(c2a_pkg::ABS_FULL) - div_quot[ABS_W-1:0];
							upd_q      <= 1'b1;
						end
						state_q <= S_PPM_MUL;
					end
				end
				S_PPM_MUL: begin
					if (abs_hold_q >= ABS_W'(c2a_pkg::ABS_PPM_MAX)) begin
						state_q <= S_DONE;
					end else begin
						seg_q   <= seg;
						prod_q  <= PROD_W'(abs_off) * PROD_W'(c2a_pkg::seg_dy(seg));
						state_q <= S_PPM_ADD;
					end
				end
				S_PPM_ADD: begin
					state_q <= S_PPM_DIV;
				end
				S_PPM_DIV: begin
					if (div_done) begin
						ppm_hold_q <= div_quot[PPM_W-1:0];
						state_q    <= S_DONE;
					end
				end
				S_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q  <= 1'b1;
						out_abs_q    <= abs_hold_q;
						out_ppm_q    <= ppm_hold_q;
						out_upd_q    <= upd_q;
						out_stable_q <= stable_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign co2_abs     = out_abs_q;
	assign co2_ppm     = out_ppm_q;
	assign abs_updated = out_upd_q;
	assign zero_stable = out_stable_q;

	a_div_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_QDIV || state_q == S_PPM_DIV))
		else $error("divider finished outside a wait state");

	a_abs_range: assert property (@(posedge clk) disable iff (!arst_n)
		abs_hold_q <= ABS_W'(c2a_pkg::ABS_FULL))
		else $error("held absorbance out of range");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_upd_q && out_stable_q))
		else $error("update and stable flags set together");

	a_accept_to_exec: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> state_q == S_EXEC)
		else $error("accepted transaction not executed");

endmodule

FILE: tb/sv/co2_absorbance_to_ppm_tb.sv
// Self-checking testbench: CO2 absorbance and ppm block against a behavioural predictor
`timescale 1ns / 1ps

module co2_absorbance_to_ppm_tb;

	localparam int CNT_W       = c2a_pkg::CNT_W;
	localparam int TEMP_W      = c2a_pkg::TEMP_W;
	localparam int TLIM_W      = c2a_pkg::TLIM_W;
	localparam int ABS_W       = c2a_pkg::ABS_W;
	localparam int PPM_W       = c2a_pkg::PPM_W;
	localparam int APB_AW      = c2a_pkg::APB_AW;
	localparam int APB_DW      = c2a_pkg::APB_DW;
	localparam int ABS_FULL    = c2a_pkg::ABS_FULL;
	localparam int ABS_PPM_MAX = c2a_pkg::ABS_PPM_MAX;

	localparam int LONG_HOLD   = 400;
	localparam int CYCLE_LIMIT = 1500000;
	localparam int PHASE_ITEMS = 350;
	localparam int NUM_PHASES  = 5;
	localparam logic [2:0] REG_UNUSED = 3'd5;

	typedef struct {
		logic [ABS_W-1:0] absorb;
		logic [PPM_W-1:0] ppm;
		logic             upd;
		logic             stable;
	} ppm_result_t;

	class ppm_scoreboard;
		ppm_result_t      expected_q[$];
		logic [CNT_W-1:0] low_rail, high_rail, cnt_limit;
		logic [TLIM_W-1:0] temp_limit;
		int               def_temp;
		logic [CNT_W-1:0] zero_cnt;
		int               zero_tmp;
		logic [ABS_W-1:0] abs_q;
		logic [PPM_W-1:0] ppm_q;
		int               errors, checked, updates, stables;
		int               req_count[4];

		function new();
			low_rail   = c2a_pkg::LOW_RAIL_RST;
			high_rail  = c2a_pkg::HIGH_RAIL_RST;
			cnt_limit  = c2a_pkg::CNT_LIMIT_RST;
			temp_limit = c2a_pkg::TEMP_LIMIT_RST;
			def_temp   = 400;
			zero_cnt   = '0;
			zero_tmp   = 400;
			abs_q      = '0;
			ppm_q      = '0;
			errors     = 0;
			checked    = 0;
			updates    = 0;
			stables    = 0;
			foreach (req_count[i]) req_count[i] = 0;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void set_reg(logic [2:0] idx, logic [31:0] val);
			case (idx)
				c2a_pkg::REG_LOW_RAIL:  low_rail = val[CNT_W-1:0];
				c2a_pkg::REG_HIGH_RAIL: high_rail = val[CNT_W-1:0];
				c2a_pkg::REG_CNT_LIM:   cnt_limit = val[CNT_W-1:0];
				c2a_pkg::REG_TEMP_LIM:  temp_limit = val[TLIM_W-1:0];
				c2a_pkg::REG_DEF_TEMP:  def_temp = int'($signed(val[TEMP_W-1:0]));
				default: ;
			endcase
		endfunction

		// five-segment piecewise linear map, truncating division
		function logic [PPM_W-1:0] interp(logic [ABS_W-1:0] a);
			int     bx[6] = '{0, 30, 83, 219, 364, 523};
			int     by[6] = '{0, 3800, 9500, 40000, 100000, 200000};
			longint num;
			for (int i = 0; i < 5; i++) begin
				if (int'(a) < bx[i+1]) begin
					num = longint'(int'(a) - bx[i]) * (by[i+1] - by[i])
						+ longint'(by[i]) * (bx[i+1] - bx[i]);
					return PPM_W'(num / (bx[i+1] - bx[i]));
				end
			end
			return ppm_q;
		endfunction

		function void note_input(logic [1:0] req, logic [CNT_W-1:0] avg, int temp);
			ppm_result_t r;
			int          q, dc, dt;
			r.upd    = 1'b0;
			r.stable = 1'b0;
			req_count[req]++;
			case (req)
				c2a_pkg::REQ_MEASURE: begin
					if (zero_cnt != 0 && zero_cnt != low_rail && zero_cnt != high_rail) begin
						q = (1000 * int'(avg)) / int'(zero_cnt);
						if (q <= ABS_FULL) begin
							abs_q = ABS_W'(ABS_FULL - q);
							r.upd = 1'b1;
							updates++;
						end
					end
					if (abs_q < ABS_PPM_MAX)
						ppm_q = interp(abs_q);
				end
				c2a_pkg::REQ_CAPTURE: begin
					zero_cnt = avg;
					zero_tmp = temp;
				end
				c2a_pkg::REQ_CHECK: begin
					dc = (avg > zero_cnt) ? int'(avg - zero_cnt) : int'(zero_cnt - avg);
					dt = (temp > zero_tmp) ? temp - zero_tmp : zero_tmp - temp;
					r.stable = (dc <= int'(cnt_limit) && dt <= int'(temp_limit));
					if (r.stable) stables++;
				end
				default: begin
					zero_cnt = avg;
					zero_tmp = def_temp;
					abs_q    = '0;
					ppm_q    = '0;
				end
			endcase
			r.absorb = abs_q;
			r.ppm    = ppm_q;
			expected_q.push_back(r);
		endfunction

		task report(string msg);
			if (errors < 40) $display("ERROR: %s", msg);
			errors++;
		endtask

		task check_result(logic [ABS_W-1:0] absorb, logic [PPM_W-1:0] ppm,
				logic upd, logic stable);
			ppm_result_t e;
			if (expected_q.size() == 0) begin
				report($sformatf("result with none pending: abs %0d ppm %0d", absorb, ppm));
				return;
			end
			e = expected_q.pop_front();
			checked++;
			if (absorb !== e.absorb)
				report($sformatf("result %0d co2_abs got %0d want %0d", checked, absorb, e.absorb));
			if (ppm !== e.ppm)
				report($sformatf("result %0d co2_ppm got %0d want %0d", checked, ppm, e.ppm));
			if (upd !== e.upd)
				report($sformatf("result %0d abs_updated got %b want %b", checked, upd, e.upd));
			if (stable !== e.stable)
				report($sformatf("result %0d zero_stable got %b want %b", checked, stable,
					e.stable));
		endtask
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 psel = 1'b0;
	logic                 penable = 1'b0;
	logic                 pwrite = 1'b0;
	logic [APB_AW-1:0]    paddr = '0;
	logic [APB_DW-1:0]    pwdata = '0;
	logic [APB_DW-1:0]    prdata;
	logic                 pready;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [1:0]           req_type = c2a_pkg::REQ_MEASURE;
	logic [CNT_W-1:0]     co2_average = '0;
	logic signed [TEMP_W-1:0] temperature = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [ABS_W-1:0]     co2_abs;
	logic [PPM_W-1:0]     co2_ppm;
	logic                 abs_updated;
	logic                 zero_stable;

	ppm_scoreboard sb;
	int            cycle_count = 0;
	int            burst_left = 0;
	int            gap_max = 40;
	int            settings = 0;
	bit            long_hold_req = 1'b0;

	co2_absorbance_to_ppm dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.req_type    (req_type),
		.co2_average (co2_average),
		.temperature (temperature),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.co2_abs     (co2_abs),
		.co2_ppm     (co2_ppm),
		.abs_updated (abs_updated),
		.zero_stable (zero_stable)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("co2_absorbance_to_ppm: mismatch");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(co2_abs, co2_ppm, abs_updated, zero_stable);
	end

	// receiver back-pressure: random stretches of modes, plus one long hold-off
	initial begin : receiver
		int mode, stretch, hold_left;
		mode = 0;
		stretch = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				if (stretch == 0) begin
					mode = $urandom_range(0, 3);
					stretch = $urandom_range(10, 150);
				end
				stretch--;
				case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 3) == 0);
					2: out_stall <= ($urandom_range(0, 3) != 0);
					default: out_stall <= 1'b1;
				endcase
			end
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.set_reg(idx, val);
		@(posedge clk);
	endtask

	task automatic set_config(input int lo, input int hi, input int cl, input int tl,
			input int dt);
		write_reg(c2a_pkg::REG_LOW_RAIL, 32'(lo));
		write_reg(c2a_pkg::REG_HIGH_RAIL, 32'(hi));
		write_reg(c2a_pkg::REG_CNT_LIM, 32'(cl));
		write_reg(c2a_pkg::REG_TEMP_LIM, 32'(tl));
		write_reg(c2a_pkg::REG_DEF_TEMP, {20'd0, dt[11:0]});
		settings++;
	endtask

	task automatic send_item(input logic [1:0] req, input logic [CNT_W-1:0] avg,
			input logic signed [TEMP_W-1:0] temp);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, gap_max);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		in_valid <= 1'b1;
		req_type <= req;
		co2_average <= avg;
		temperature <= temp;
		do @(posedge clk); while (in_stall);
		sb.note_input(req, avg, int'(temp));
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		burst_left = 0;
	endtask

	function automatic logic [CNT_W-1:0] pick_zero();
		case ($urandom_range(0, 19))
			0: return sb.low_rail;
			1: return sb.high_rail;
			2: return '0;
			default: return CNT_W'($urandom_range(1, 1023));
		endcase
	endfunction

	function automatic int clamp(input int v, input int lo, input int hi);
		return (v < lo) ? lo : (v > hi) ? hi : v;
	endfunction

	task automatic send_random();
		int                       r, d, lim;
		logic [1:0]               req;
		logic [CNT_W-1:0]         avg;
		logic signed [TEMP_W-1:0] temp;
		r = $urandom_range(0, 99);
		avg = CNT_W'($urandom_range(0, 1023));
		temp = TEMP_W'($urandom_range(0, 4095));
		if (r < 60) begin
			req = c2a_pkg::REQ_MEASURE;
			if (sb.zero_cnt != 0 && $urandom_range(0, 99) < 85)
				avg = CNT_W'($urandom_range(0, sb.zero_cnt));
		end else if (r < 70) begin
			req = c2a_pkg::REQ_CAPTURE;
			avg = pick_zero();
		end else if (r < 90) begin
			req = c2a_pkg::REQ_CHECK;
			if ($urandom_range(0, 9) < 7) begin
				lim = int'(sb.cnt_limit) + 2;
				d = int'($urandom_range(0, 2 * lim)) - lim;
				avg = CNT_W'(clamp(int'(sb.zero_cnt) + d, 0, 1023));
				lim = int'(sb.temp_limit) + 2;
				d = int'($urandom_range(0, 2 * lim)) - lim;
				temp = TEMP_W'(clamp(sb.zero_tmp + d, -2048, 2047));
			end
		end else begin
			req = c2a_pkg::REQ_INIT;
			avg = pick_zero();
		end
		send_item(req, avg, temp);
	endtask

	initial begin
		int absv[13];
		sb = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero invalid after reset, segment boundaries, range and limit edges
		send_item(c2a_pkg::REQ_MEASURE, 10'd500, 12'sd400);
		send_item(c2a_pkg::REQ_CHECK, 10'd0, 12'sd400);
		send_item(c2a_pkg::REQ_INIT, 10'd1000, 12'sd0);
		absv = '{0, 29, 30, 82, 83, 218, 219, 363, 364, 522, 523, 1000, 999};
		foreach (absv[i]) send_item(c2a_pkg::REQ_MEASURE, CNT_W'(1000 - absv[i]), 12'sd100);
		send_item(c2a_pkg::REQ_MEASURE, 10'd1023, 12'sd100);
		send_item(c2a_pkg::REQ_CHECK, 10'd1004, 12'sd416);
		send_item(c2a_pkg::REQ_CHECK, 10'd996, 12'sd384);
		send_item(c2a_pkg::REQ_CHECK, 10'd1005, 12'sd400);
		send_item(c2a_pkg::REQ_CHECK, 10'd1000, 12'sd417);
		send_item(c2a_pkg::REQ_CAPTURE, 10'd1023, 12'sh800);
		send_item(c2a_pkg::REQ_MEASURE, 10'd0, 12'sd0);
		send_item(c2a_pkg::REQ_CAPTURE, 10'd0, 12'sd2047);
		send_item(c2a_pkg::REQ_MEASURE, 10'd0, 12'sd0);
		send_item(c2a_pkg::REQ_CHECK, 10'd0, 12'sd2047);
		send_item(c2a_pkg::REQ_INIT, 10'd1023, -12'sd1);

		for (int p = 0; p < NUM_PHASES; p++) begin
			drain();
			case (p)
				0: begin
					set_config(0, 1023, 4, 16, 400);
					write_reg(REG_UNUSED, 32'hFFFF_FFFF);
					gap_max = 40;
				end
				1: begin
					set_config(1023, 0, 1023, 2047, -2048);
					gap_max = 70;
				end
				2: begin
					set_config(0, 0, 0, 0, 2047);
					gap_max = 0;
				end
				default: begin
					set_config($urandom_range(0, 1023), $urandom_range(0, 1023),
						$urandom_range(0, 40), $urandom_range(0, 200),
						int'($urandom_range(0, 4095)) - 2048);
					gap_max = (p == 3) ? 10 : 70;
				end
			endcase
			if (p > 0) begin
				send_item(c2a_pkg::REQ_INIT, pick_zero(), 12'sd0);
			end
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (p == 0 && n == 100) long_hold_req = 1'b1;
				send_random();
			end
		end

		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
		if (sb.pending() != 0)
			sb.report($sformatf("%0d results never arrived", sb.pending()));

		$display("covered %0d measure, %0d capture, %0d check, %0d init transactions",
			sb.req_count[c2a_pkg::REQ_MEASURE], sb.req_count[c2a_pkg::REQ_CAPTURE],
			sb.req_count[c2a_pkg::REQ_CHECK], sb.req_count[c2a_pkg::REQ_INIT]);
		$display("%0d register settings, %0d absorbance updates, %0d stable checks, %0d compared",
			settings, sb.updates, sb.stables, sb.checked);
		if (sb.errors == 0) begin
			$display("co2_absorbance_to_ppm: match");
		end else begin
			$display("co2_absorbance_to_ppm: mismatch");
		end
		$finish;
	end

endmodule
